@@ rtl/mandelbrot_escape_time_assert.svh @@
// Assertion macros for the escape-time block.
// Used by the top level; relies on clk_i and rst_ni in the including scope.
`ifndef MANDELBROT_ESCAPE_TIME_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_ASSERT_SVH

`define MBE_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define MBE_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mbe_pkg.sv @@
// Shared types and constants of the escape-time block.
// No dependencies.
package mbe_pkg;
  localparam int unsigned PIX_W  = 12;
  localparam int unsigned REG_W  = 32;
  localparam int unsigned DIM_W  = 13;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned SPAN_W = REG_W + 1;
  localparam int unsigned NUM_W  = PIX_W + 1 + SPAN_W;
  localparam int unsigned MAG_W  = NUM_W - 1;
  localparam int unsigned CW     = 48;

  localparam logic [IDX_W-1:0] REG_REAL_MIN     = 3'd0;
  localparam logic [IDX_W-1:0] REG_REAL_MAX     = 3'd1;
  localparam logic [IDX_W-1:0] REG_IMAG_MIN     = 3'd2;
  localparam logic [IDX_W-1:0] REG_IMAG_MAX     = 3'd3;
  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 3'd4;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 3'd5;

  typedef struct packed {
    logic signed [REG_W-1:0] real_min;
    logic signed [REG_W-1:0] real_max;
    logic signed [REG_W-1:0] imag_min;
    logic signed [REG_W-1:0] imag_max;
    logic [DIM_W-1:0]        frame_width;
    logic [DIM_W-1:0]        frame_height;
  } cfg_t;

  typedef struct packed {
    logic signed [CW-1:0] cr;
    logic signed [CW-1:0] ci;
  } coord_t;

  typedef struct packed {
    logic   valid;
    coord_t coord;
  } coord_req_t;
endpackage

@@ rtl/mandelbrot_escape_time.sv @@
// Top level of the escape-time block: configuration registers, front end,
// queue and back end. Uses mbe_pkg, mbe_front, mbe_queue, mbe_back.
//
// Usage: a request on the input channel (in_valid_i, in_stall_o) carries one
// pixel position. The block maps it into the configured rectangle and
// returns one result request on the output channel (out_valid_o,
// out_stall_i) with the escape count and a gray pixel.
// The coordinate mapping (two 45-step restoring dividers) and the queue come
// first, then the completed iterations of the back end's multipliers, at most
// MAX_ITER, plus the final escape test, and last the output register. The
// iteration loop sets the throughput, with the next pixel mapped meanwhile.
// The configuration channel (cfg_valid_i, cfg_ready_o) is always ready;
// write only while the block is idle. Unknown indexes are ignored.
// Reset restores the rectangle to -1.0..+1.0 in both axes and a 600 by 600
// frame, and empties the pipeline.
// While the receiver stalls, the result is held; the back end then waits
// with its next result and the front end fills the two-entry queue.
module mandelbrot_escape_time #(
  parameter int MAX_ITER  = 255,
  parameter int MAX_DIM   = 4096,
  parameter int FRAC_BITS = 28
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [11:0] pixel_x_i,
  input  logic [11:0] pixel_y_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  escape_count_o,
  output logic [23:0] gray_pixel_o
);
  import mbe_pkg::*;

  cfg_t       cfg_q;
  coord_req_t push;
  coord_t     q_data;
  logic       q_full, q_valid, q_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.real_min     <= -32'sd268435456;
      cfg_q.real_max     <= 32'sd268435456;
      cfg_q.imag_min     <= -32'sd268435456;
      cfg_q.imag_max     <= 32'sd268435456;
      cfg_q.frame_width  <= 13'd600;
      cfg_q.frame_height <= 13'd600;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_REAL_MIN:     cfg_q.real_min     <= cfg_data_i;
        REG_REAL_MAX:     cfg_q.real_max     <= cfg_data_i;
        REG_IMAG_MIN:     cfg_q.imag_min     <= cfg_data_i;
        REG_IMAG_MAX:     cfg_q.imag_max     <= cfg_data_i;
        REG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data_i[DIM_W-1:0];
        REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  mbe_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .in_valid_i, .in_stall_o,
    .pixel_x_i, .pixel_y_i, .push_o(push), .full_i(q_full)
  );

  mbe_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .full_o(q_full), .valid_o(q_valid),
    .data_o(q_data), .pop_i(q_pop)
  );

  mbe_back #(.MAX_ITER(MAX_ITER), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .valid_i(q_valid), .data_i(q_data), .pop_o(q_pop),
    .out_valid_o, .out_stall_i, .escape_count_o, .gray_pixel_o
  );

`include "mandelbrot_escape_time_assert.svh"

  `MBE_ASSERT_IMP(a_no_overflow, push.valid, !q_full, "queue written while full")
  `MBE_ASSERT_IMP(a_pop_valid, q_pop, q_valid, "queue read while empty")
  `MBE_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o,
                  "front end not busy after accepting a request")
  `MBE_ASSERT_IMP(a_gray, out_valid_o,
                  gray_pixel_o == {escape_count_o, escape_count_o, escape_count_o},
                  "gray pixel differs from escape count")
endmodule

@@ rtl/mbe_front.sv @@
// Front end: accepts a pixel and maps it into the complex rectangle.
// Uses mbe_pkg; two restoring dividers run side by side, one bit per cycle.
module mbe_front #(
  parameter int MAX_DIM = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mbe_pkg::cfg_t       cfg_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [11:0]         pixel_x_i,
  input  logic [11:0]         pixel_y_i,
  output mbe_pkg::coord_req_t push_o,
  input  logic                full_i
);
  import mbe_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_DIV  = 2'd2;
  localparam logic [1:0] F_FIN  = 2'd3;
  localparam int unsigned CNT_W = $clog2(MAG_W);

  logic [1:0]        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q;
  logic [PIX_W-1:0]  pix_q  [2];
  logic [MAG_W-1:0]  mag_q  [2];
  logic [DIM_W-1:0]  rem_q  [2];
  logic              neg_q  [2];

  logic signed [REG_W-1:0] lo    [2];
  logic signed [REG_W-1:0] hi    [2];
  logic [DIM_W-1:0]        dim   [2];
  logic signed [NUM_W-1:0] num   [2];
  logic [MAG_W-1:0]        mag   [2];
  logic [DIM_W:0]          rem2  [2];
  logic                    ge    [2];
  logic [DIM_W-1:0]        rem_n [2];
  logic signed [CW-1:0]    res   [2];
  logic                    accept;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    if (d == '0) begin
      return DIM_W'(1);
    end else if (32'(d) > MAX_DIM) begin
      return DIM_W'(MAX_DIM);
    end
    return d;
  endfunction

  assign lo[0]  = cfg_i.real_min;
  assign hi[0]  = cfg_i.real_max;
  assign dim[0] = clamp_dim(cfg_i.frame_width);
  assign lo[1]  = cfg_i.imag_min;
  assign hi[1]  = cfg_i.imag_max;
  assign dim[1] = clamp_dim(cfg_i.frame_height);

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      num[i] = NUM_W'($signed({1'b0, pix_q[i]})) *
               NUM_W'(SPAN_W'(hi[i]) - SPAN_W'(lo[i]));
      mag[i] = num[i][NUM_W-1] ? MAG_W'(-num[i]) : MAG_W'(num[i]);
      rem2[i] = {rem_q[i], mag_q[i][MAG_W-1]};
      ge[i] = rem2[i] >= {1'b0, dim[i]};
      rem_n[i] = ge[i] ? DIM_W'(rem2[i] - {1'b0, dim[i]}) : DIM_W'(rem2[i]);
      res[i] = CW'(lo[i]) + (neg_q[i] ? -CW'(mag_q[i]) : CW'(mag_q[i]));
    end
  end

  assign in_stall_o = (state_q != F_IDLE);
  assign accept = in_valid_i && !in_stall_o;
  assign push_o.valid = (state_q == F_FIN) && !full_i;
  assign push_o.coord.cr = res[0];
  assign push_o.coord.ci = res[1];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: if (accept) state_d = F_MUL;
      F_MUL:  state_d = F_DIV;
      F_DIV:  if (cnt_q == CNT_W'(MAG_W - 1)) state_d = F_FIN;
      F_FIN:  if (!full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q[0] <= pixel_x_i;
      pix_q[1] <= pixel_y_i;
    end
    if (state_q == F_MUL) begin
      cnt_q <= '0;
      for (int i = 0; i < 2; i++) begin
        mag_q[i] <= mag[i];
        neg_q[i] <= num[i][NUM_W-1];
        rem_q[i] <= '0;
      end
    end else if (state_q == F_DIV) begin
      cnt_q <= cnt_q + CNT_W'(1);
      for (int i = 0; i < 2; i++) begin
        mag_q[i] <= {mag_q[i][MAG_W-2:0], ge[i]};
        rem_q[i] <= rem_n[i];
      end
    end
  end
endmodule

@@ rtl/mbe_queue.sv @@
// Two-entry queue of mapped coordinates between front and back end.
// Uses mbe_pkg.
module mbe_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mbe_pkg::coord_req_t push_i,
  output logic                full_o,
  output logic                valid_o,
  output mbe_pkg::coord_t     data_o,
  input  logic                pop_i
);
  import mbe_pkg::*;

  coord_t     mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_q] <= push_i.coord;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i.valid) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i.valid) - 2'(pop_i);
    end
  end
endmodule

@@ rtl/mbe_back.sv @@
// Back end: iterates z = z^2 + c and holds the result register.
// Uses mbe_pkg; three multipliers, each iteration steps through B_MUL and B_ADD.
module mbe_back #(
  parameter int MAX_ITER  = 255,
  parameter int FRAC_BITS = 28
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  mbe_pkg::coord_t data_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      escape_count_o,
  output logic [23:0]     gray_pixel_o
);
  import mbe_pkg::*;

  localparam int VW = (CW > FRAC_BITS + 8) ? CW : FRAC_BITS + 8;
  localparam int MW = FRAC_BITS + 3;
  localparam int PW = 2 * MW;
  localparam int IW = $clog2(MAX_ITER + 1);
  localparam logic signed [VW-1:0] TWO =
    {{(VW-FRAC_BITS-2){1'b0}}, 1'b1, {(FRAC_BITS+1){1'b0}}};
  localparam logic signed [VW-1:0] FOUR =
    {{(VW-FRAC_BITS-3){1'b0}}, 1'b1, {(FRAC_BITS+2){1'b0}}};

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_MUL  = 2'd1;
  localparam logic [1:0] B_ADD  = 2'd2;
  localparam logic [1:0] B_DONE = 2'd3;

  logic [1:0]           state_q, state_d;
  logic signed [VW-1:0] cr_q, ci_q, nr_q, ni_q;
  logic signed [PW-1:0] pr_q, pi_q, px_q;
  logic [IW-1:0]        n_q;
  logic                 out_valid_q;
  logic [7:0]           out_cnt_q;

  logic                 out_free, bound_fail, sum_fail, last;
  logic signed [MW-1:0] a, b;
  logic signed [VW-1:0] sr, si, nr_n, ni_n;

  assign out_free = !out_valid_q || !out_stall_i;
  assign bound_fail = (nr_q > TWO) || (nr_q < -TWO) || (ni_q > TWO) || (ni_q < -TWO);
  assign a = MW'(nr_q);
  assign b = MW'(ni_q);
  assign sr = VW'(pr_q >>> FRAC_BITS);
  assign si = VW'(pi_q >>> FRAC_BITS);
  assign sum_fail = (sr + si) > FOUR;
  assign last = (n_q + IW'(1)) == IW'(MAX_ITER);
  assign nr_n = sr - si + cr_q;
  assign ni_n = VW'(px_q >>> (FRAC_BITS - 1)) + ci_q;
  assign pop_o = (state_q == B_IDLE) && valid_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: if (valid_i) state_d = B_MUL;
      B_MUL:  state_d = bound_fail ? B_DONE : B_ADD;
      B_ADD:  state_d = (sum_fail || last) ? B_DONE : B_MUL;
      B_DONE: if (out_free) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      B_IDLE: begin
        cr_q <= VW'(data_i.cr);
        ci_q <= VW'(data_i.ci);
        nr_q <= VW'(data_i.cr);
        ni_q <= VW'(data_i.ci);
        n_q  <= '0;
      end
      B_MUL: begin
        pr_q <= PW'(a) * PW'(a);
        pi_q <= PW'(b) * PW'(b);
        px_q <= PW'(a) * PW'(b);
      end
      B_ADD: begin
        if (!sum_fail) begin
          n_q  <= n_q + IW'(1);
          nr_q <= nr_n;
          ni_q <= ni_n;
        end
      end
      B_DONE: begin
        if (out_free) begin
          out_cnt_q <= (32'(n_q) > 255) ? 8'hFF : 8'(n_q);
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign escape_count_o = out_cnt_q;
  assign gray_pixel_o   = {out_cnt_q, out_cnt_q, out_cnt_q};
endmodule
